// ----- design/mp2a_pkg.sv -----
// Shared types, constants and a helper function for the masked pixel converter.
`default_nettype none
package mp2a_pkg;

    localparam int NUM_CH    = 3;
    localparam int DIV_STEPS = 8;
    localparam int REM_W     = 40;
    localparam int DEN_W     = 39;

    localparam logic [31:0] FALLBACK_RED   = 32'h00ff_0000;
    localparam logic [31:0] FALLBACK_GREEN = 32'h0000_ff00;
    localparam logic [31:0] FALLBACK_BLUE  = 32'h0000_00ff;
    localparam logic [7:0]  ALPHA_OPAQUE   = 8'hff;

    localparam logic [2:0] REG_RED_MASK    = 3'd0;
    localparam logic [2:0] REG_GREEN_MASK  = 3'd1;
    localparam logic [2:0] REG_BLUE_MASK   = 3'd2;
    localparam logic [2:0] REG_PIXEL_BYTES = 3'd3;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [7:0]       quo;
    } t_div;

    function automatic logic [4:0] tz_count(input logic [31:0] m);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- design/mp2a_front.sv -----
// Front stages: byte masking, mask fallback, channel extraction and numerator build.
`default_nettype none
module mp2a_front
    import mp2a_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [31:0]                  i_raw_pixel,
    input  wire logic [NUM_CH-1:0][31:0]      i_masks,
    input  wire logic [2:0]                   i_pixel_bytes,
    output t_div      [NUM_CH-1:0]            o_div
);

    logic [31:0]              n_pix;
    logic [NUM_CH-1:0][31:0]  n_mask;
    logic [NUM_CH-1:0][31:0]  r_mask;
    logic [NUM_CH-1:0][31:0]  r_bits;
    logic [NUM_CH-1:0][4:0]   r_sh;
    t_div [NUM_CH-1:0]        n_div;
    t_div [NUM_CH-1:0]        r_div;

    always_comb begin
        case (i_pixel_bytes)
            3'd1:    n_pix = i_raw_pixel & 32'h0000_00ff;
            3'd2:    n_pix = i_raw_pixel & 32'h0000_ffff;
            3'd3:    n_pix = i_raw_pixel & 32'h00ff_ffff;
            default: n_pix = i_raw_pixel;
        endcase
        if (i_masks[CH_RED] == 32'd0 || i_masks[CH_GREEN] == 32'd0 ||
            i_masks[CH_BLUE] == 32'd0) begin
            n_mask[CH_RED]   = FALLBACK_RED;
            n_mask[CH_GREEN] = FALLBACK_GREEN;
            n_mask[CH_BLUE]  = FALLBACK_BLUE;
        end else begin
            n_mask = i_masks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_mask[c] <= n_mask[c];
                r_bits[c] <= n_pix & n_mask[c];
                r_sh[c]   <= tz_count(n_mask[c]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            logic [31:0] mx;
            logic [31:0] v;
            mx = r_mask[c] >> r_sh[c];
            v  = r_bits[c] >> r_sh[c];
            n_div[c].rem = ({8'd0, v} << 8) - {8'd0, v} + {9'd0, mx[31:1]};
            n_div[c].den = {mx, 7'd0};
            n_div[c].quo = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule
`default_nettype wire

// ----- design/mp2a_div_cell.sv -----
// One restoring division cell: settles a single quotient bit and passes the rest on.
`default_nettype none
module mp2a_div_cell
    import mp2a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  t_div      i_cell,
    output t_div      o_cell
);

    t_div n_cell;
    t_div r_cell;

    always_comb begin
        n_cell.den = i_cell.den >> 1;
        if (i_cell.rem >= {1'b0, i_cell.den}) begin
            n_cell.rem = i_cell.rem - {1'b0, i_cell.den};
            n_cell.quo = {i_cell.quo[6:0], 1'b1};
        end else begin
            n_cell.rem = i_cell.rem;
            n_cell.quo = {i_cell.quo[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule
`default_nettype wire

// ----- design/masked_pixel_to_argb8888_core.sv -----
// Top level of the masked raw pixel to ARGB8888 converter.
// Usage:
//   Raw pixels enter on i_raw_pixel under i_valid / o_ready, held in the low
//   bytes; converted pixels leave on o_alpha_out, o_red_out, o_green_out and
//   o_blue_out under o_valid / i_ready. An item moves when valid and ready are high.
//   Masks and the pixel size are written through i_cfg_we, i_cfg_index and
//   i_cfg_data; the user must write them only while no item is in flight, which
//   the block does not enforce. The write takes effect at once. Items pass two
//   front stages, then a row of eight division cells per channel, each settling
//   one quotient bit of (v*255 + max/2)/max. Throughput is one item per cycle
//   while the output is not stalled; every stage advances together. When the
//   receiver stalls with a result waiting, the whole row holds and o_ready falls;
//   it rises again as soon as the result is taken. Reset restores the default
//   XRGB8888 masks and a size of four bytes and empties the pipeline; no clearing pass is needed.
`default_nettype none
module masked_pixel_to_argb8888_core
    import mp2a_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_raw_pixel,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_alpha_out,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int LAT = 2 + DIV_STEPS;

    logic [NUM_CH-1:0][31:0] r_masks;
    logic [2:0]              r_pixel_bytes;
    logic [LAT-1:0]          r_vld;
    logic                    advance;
    t_div [NUM_CH-1:0]       front_div;
    t_div [NUM_CH-1:0]       chain [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_masks[CH_RED]   <= FALLBACK_RED;
            r_masks[CH_GREEN] <= FALLBACK_GREEN;
            r_masks[CH_BLUE]  <= FALLBACK_BLUE;
            r_pixel_bytes     <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RED_MASK:    r_masks[CH_RED]   <= i_cfg_data;
                REG_GREEN_MASK:  r_masks[CH_GREEN] <= i_cfg_data;
                REG_BLUE_MASK:   r_masks[CH_BLUE]  <= i_cfg_data;
                REG_PIXEL_BYTES: r_pixel_bytes     <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    assign advance = !r_vld[LAT-1] || i_ready;
    assign o_ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    mp2a_front u_front (
        .i_clk         (i_clk),
        .i_en          (advance),
        .i_raw_pixel   (i_raw_pixel),
        .i_masks       (r_masks),
        .i_pixel_bytes (r_pixel_bytes),
        .o_div         (front_div)
    );

    assign chain[0] = front_div;

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
            mp2a_div_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (advance),
                .i_cell (chain[s][c]),
                .o_cell (chain[s+1][c])
            );
        end
    end

    assign o_valid     = r_vld[LAT-1];
    assign o_alpha_out = ALPHA_OPAQUE;
    assign o_red_out   = chain[DIV_STEPS][CH_RED].quo;
    assign o_green_out = chain[DIV_STEPS][CH_GREEN].quo;
    assign o_blue_out  = chain[DIV_STEPS][CH_BLUE].quo;

endmodule
`default_nettype wire

// ----- design/mp2a_checker.sv -----
// Port-level checker for the converter top level, with its bind statement.
`default_nettype none
module mp2a_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_alpha_out,
    input wire logic [7:0] o_red_out,
    input wire logic [7:0] o_green_out,
    input wire logic [7:0] o_blue_out
);

    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("Result shown straight after reset.");

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("Input ready does not follow the output stage.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_red_out) &&
        $stable(o_green_out) && $stable(o_blue_out))
        else $error("Stalled item changed or vanished.");

    a_alpha_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_alpha_out == 8'hff)
        else $error("Alpha is not opaque.");

endmodule

bind masked_pixel_to_argb8888_core mp2a_checker u_mp2a_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_alpha_out (o_alpha_out),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out)
);
`default_nettype wire
